FILE: design/gme_pkg.sv
`default_nettype none
package gme_pkg;

  // config register indexes
  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_MODE   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_e;

  localparam int unsigned KS_W      = 4;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned EDGE_W    = 3;
  localparam int unsigned PIX_W_MAX = 16;

  localparam logic [KS_W-1:0]  KS_RST     = 4'd3;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

  // per-item control travelling down the pipe
  typedef struct packed {
    logic valid;
    logic has_out;
    logic eof;
    logic err;
    logic erode;
  } ctl_t;

  // max for dilation, min for erosion
  function automatic logic [PIX_W_MAX-1:0] pick(input logic [PIX_W_MAX-1:0] a,
                                                input logic [PIX_W_MAX-1:0] b,
                                                input logic erode);
    if (erode) begin
      return (b < a) ? b : a;
    end else begin
      return (b > a) ? b : a;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/gme_ctrl.sv
`default_nettype none
module gme_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15,
  parameter int PIXEL_BITS = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  wire                            in_valid_i,
  input  wire [PIXEL_BITS-1:0]           pixel_i,
  input  wire                            flush_i,
  input  wire [gme_pkg::KS_W-1:0]        ks_i,
  input  wire                            erode_i,
  input  wire [gme_pkg::DIM_W-1:0]       width_i,
  input  wire [gme_pkg::DIM_W-1:0]       height_i,
  output gme_pkg::ctl_t                  ctl_o,
  output logic [PIXEL_BITS-1:0]          pix_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_o,
  output logic [2*((MAX_KERNEL-1)/2):0]  vmask_o,
  output logic [2*((MAX_KERNEL-1)/2):0]  hmask_o
);
  import gme_pkg::*;

  localparam int EM  = (MAX_KERNEL - 1) / 2;
  localparam int NT  = 2 * EM + 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int TW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_KERNEL * MAX_WIDTH + 1);

  logic [CW-1:0]  in_col_q, in_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [ORW-1:0] out_row_q, out_row_d;
  logic [TW-1:0]  t_q, t_d;

  logic [WW-1:0]     w;
  logic [HW-1:0]     h;
  logic [EDGE_W-1:0] edge_w;
  logic [TW-1:0]     lag;
  logic              in_img, proc, has_out, last_out;
  logic [NT-1:0]     vm, hm;

  always_comb begin
    if (width_i == '0) begin
      w = WW'(1);
    end else if (32'(width_i) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_i);
    end
    if (height_i == '0) begin
      h = HW'(1);
    end else if (32'(height_i) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_i);
    end
    if (int'(ks_i[KS_W-1:1]) > EM) begin
      edge_w = EDGE_W'(EM);
    end else begin
      edge_w = ks_i[KS_W-1:1];
    end
    lag      = TW'(int'(edge_w) * int'(w) + int'(edge_w));
    in_img   = int'(in_row_q) < int'(h);
    proc     = in_valid_i && en_i && !(flush_i && in_img);
    has_out  = t_q >= lag;
    last_out = has_out && (int'(out_row_q) == int'(h) - 1) &&
               (int'(out_col_q) == int'(w) - 1);
    for (int j = 0; j < NT; j++) begin
      vm[j] = (j <= 2 * int'(edge_w)) && (j <= int'(in_row_q)) &&
              (int'(in_row_q) < int'(h) + j);
      hm[j] = (j <= 2 * int'(edge_w)) && (j <= int'(out_col_q) + int'(edge_w)) &&
              (int'(out_col_q) + int'(edge_w) < int'(w) + j);
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    t_d       = t_q;
    if (proc) begin
      if (last_out) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        t_d       = '0;
      end else begin
        t_d = t_q + TW'(1);
        if (int'(in_col_q) + 1 >= int'(w)) begin
          in_col_d = '0;
          in_row_d = in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
        if (has_out) begin
          if (int'(out_col_q) + 1 >= int'(w)) begin
            out_col_d = '0;
            out_row_d = out_row_q + ORW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      t_q       <= '0;
      ctl_o     <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      t_q       <= t_d;
      if (en_i) begin
        ctl_o.valid   <= proc;
        ctl_o.has_out <= has_out;
        ctl_o.eof     <= last_out;
        ctl_o.err     <= ~ks_i[0];
        ctl_o.erode   <= erode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_o   <= pixel_i;
      col_o   <= in_col_q;
      vmask_o <= vm;
      hmask_o <= hm;
    end
  end

endmodule
`default_nettype wire

FILE: design/gme_vert.sv
`default_nettype none
module gme_vert #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 15,
  parameter int PIXEL_BITS = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 en_i,
  input  gme_pkg::ctl_t                       ctl_i,
  input  wire [PIXEL_BITS-1:0]                pix_i,
  input  wire [$clog2(MAX_WIDTH)-1:0]         col_i,
  input  wire [2*((MAX_KERNEL-1)/2):0]        vmask_i,
  input  wire [2*((MAX_KERNEL-1)/2):0]        hmask_i,
  output gme_pkg::ctl_t                       ctl_o,
  output logic [PIXEL_BITS-1:0]               v_o,
  output logic [2*((MAX_KERNEL-1)/2):0]       hmask_o
);
  import gme_pkg::*;

  localparam int EM = (MAX_KERNEL - 1) / 2;
  localparam int NT = 2 * EM + 1;
  localparam int NL = NT - 1;
  localparam int NG = (NT + 3) / 4;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;

  // line memory: one word per column, lane i = row (current - 1 - i)
  logic [NL*PB-1:0] mem [MAX_WIDTH];
  logic [NL*PB-1:0] rd_q, fwd_word_q, word, new_word;
  logic             fwd_q;

  ctl_t          ctl2_q, ctl3_q;
  logic [PB-1:0] pix2_q;
  logic [CW-1:0] col2_q;
  logic [NT-1:0] vmask2_q, hmask2_q, hmask3_q;
  logic [PB-1:0] grp_d [NG];
  logic [PB-1:0] grp3_q [NG];
  logic [PB-1:0] vals [NT];
  logic [PB-1:0] v_d;
  logic [PB-1:0] ident2, ident3;

  always_comb begin
    logic [PIX_W_MAX-1:0] acc;
    word     = fwd_q ? fwd_word_q : rd_q;
    new_word = {word[(NL-1)*PB-1:0], pix2_q};
    ident2   = ctl2_q.erode ? '1 : '0;
    vals[0]  = pix2_q;
    for (int j = 1; j < NT; j++) begin
      vals[j] = word[(j-1)*PB +: PB];
    end
    for (int g = 0; g < NG; g++) begin
      acc = PIX_W_MAX'(ident2);
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < NT) begin
          if (vmask2_q[4*g+i]) begin
            acc = pick(acc, PIX_W_MAX'(vals[4*g+i]), ctl2_q.erode);
          end
        end
      end
      grp_d[g] = acc[PB-1:0];
    end
  end

  always_comb begin
    logic [PIX_W_MAX-1:0] acc;
    ident3 = ctl3_q.erode ? '1 : '0;
    acc    = PIX_W_MAX'(ident3);
    for (int g = 0; g < NG; g++) begin
      acc = pick(acc, PIX_W_MAX'(grp3_q[g]), ctl3_q.erode);
    end
    v_d = acc[PB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctl_i.valid) begin
        rd_q <= mem[col_i];
      end
      if (ctl2_q.valid) begin
        mem[col2_q] <= new_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl_o  <= '0;
      fwd_q  <= 1'b0;
    end else if (en_i) begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
      ctl_o  <= ctl3_q;
      // item behind reads the column this one writes now
      fwd_q  <= ctl2_q.valid && (col2_q == col_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix2_q     <= pix_i;
      col2_q     <= col_i;
      vmask2_q   <= vmask_i;
      hmask2_q   <= hmask_i;
      fwd_word_q <= new_word;
      grp3_q     <= grp_d;
      hmask3_q   <= hmask2_q;
      v_o        <= v_d;
      hmask_o    <= hmask3_q;
    end
  end

endmodule
`default_nettype wire

FILE: design/gme_horz.sv
`default_nettype none
module gme_horz #(
  parameter int MAX_KERNEL = 15,
  parameter int PIXEL_BITS = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  gme_pkg::ctl_t                  ctl_i,
  input  wire [PIXEL_BITS-1:0]           v_i,
  input  wire [2*((MAX_KERNEL-1)/2):0]   hmask_i,
  output logic                           out_valid_o,
  output logic [PIXEL_BITS-1:0]          out_pix_o,
  output logic                           out_eof_o,
  output logic                           out_err_o
);
  import gme_pkg::*;

  localparam int EM = (MAX_KERNEL - 1) / 2;
  localparam int NT = 2 * EM + 1;
  localparam int NG = (NT + 3) / 4;
  localparam int PB = PIXEL_BITS;

  // column results of earlier items, newest first
  logic [PB-1:0] hline_q [NT-1];
  logic [PB-1:0] taps [NT];
  logic [PB-1:0] grp_d [NG];
  logic [PB-1:0] grp5_q [NG];
  logic [PB-1:0] fin;
  logic [PB-1:0] ident4, ident5;
  ctl_t          ctl5_q;

  always_comb begin
    logic [PIX_W_MAX-1:0] acc;
    ident4  = ctl_i.erode ? '1 : '0;
    taps[0] = v_i;
    for (int k = 1; k < NT; k++) begin
      taps[k] = hline_q[k-1];
    end
    for (int g = 0; g < NG; g++) begin
      acc = PIX_W_MAX'(ident4);
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < NT) begin
          if (hmask_i[4*g+i]) begin
            acc = pick(acc, PIX_W_MAX'(taps[4*g+i]), ctl_i.erode);
          end
        end
      end
      grp_d[g] = acc[PB-1:0];
    end
  end

  always_comb begin
    logic [PIX_W_MAX-1:0] acc;
    ident5 = ctl5_q.erode ? '1 : '0;
    acc    = PIX_W_MAX'(ident5);
    for (int g = 0; g < NG; g++) begin
      acc = pick(acc, PIX_W_MAX'(grp5_q[g]), ctl5_q.erode);
    end
    fin = acc[PB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl5_q      <= '0;
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      ctl5_q      <= ctl_i;
      out_valid_o <= ctl5_q.valid && ctl5_q.has_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctl_i.valid) begin
        hline_q[0] <= v_i;
        for (int k = 1; k < NT - 1; k++) begin
          hline_q[k] <= hline_q[k-1];
        end
      end
      grp5_q    <= grp_d;
      out_pix_o <= ctl5_q.err ? '0 : fin;
      out_eof_o <= ctl5_q.eof;
      out_err_o <= ctl5_q.err;
    end
  end

endmodule
`default_nettype wire

FILE: design/grayscale_morph_erode_dilate.sv
// Flat square grayscale erosion / dilation on a raster pixel stream.
// Input stream (s_axis): one pixel per item; tuser flags a flush item that
// drains the frame tail. After the last pixel of a frame the source sends
// edge*width+edge flush items, edge = kernel_size/2.
// Output stream (m_axis): one result per pixel position, max (dilation) or
// min (erosion) over the window clipped to the image; tlast marks the last
// pixel of the frame, tuser flags an even kernel size (pixel then zero).
// Config port: cfg_we_i/cfg_idx_i/cfg_data_i, write only while idle.
// Throughput: one item per clock unless the output stalls, set by the line
// memory, which takes one read and one write per item (read-modify-write
// with forwarding). In items the output lags the input by edge*width+edge;
// a result leaves once the item completing its window has passed the pipe.
// Pipeline: counters/masks, line memory read, column reduce (2 stages),
// row reduce (2 stages) into the output register.
// Reset: counters and valids clear, registers go to 3/0/640/480; the line
// memory is not cleared (every read entry is written first in a frame).
// Stall: when the output register is full and not taken the whole pipe
// holds and s_axis_tready drops; nothing is lost or repeated.
`default_nettype none
module grayscale_morph_erode_dilate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15,
  parameter int PIXEL_BITS = 8
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire [((PIXEL_BITS+7)/8)*8-1:0]        s_axis_tdata,  // pixel_in
  input  wire                                   s_axis_tuser,  // flush
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_axis_tdata,  // pixel_out
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tuser,  // config_error
  input  wire                                   cfg_we_i,
  input  wire [1:0]                             cfg_idx_i,
  input  wire [gme_pkg::CFG_W-1:0]              cfg_data_i
);
  import gme_pkg::*;

  localparam int EM  = (MAX_KERNEL - 1) / 2;
  localparam int NT  = 2 * EM + 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8;

  logic [KS_W-1:0]  ks_q;
  logic             erode_q;
  logic [DIM_W-1:0] width_q, height_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q     <= KS_RST;
      erode_q  <= 1'b0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KERNEL: ks_q     <= cfg_data_i[KS_W-1:0];
        REG_MODE:   erode_q  <= cfg_data_i[0];
        REG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
      endcase
    end
  end

  // global advance: output register free or being taken
  logic en;
  logic out_valid;
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  ctl_t                  ctl1, ctl4;
  logic [PIXEL_BITS-1:0] pix1, v4, out_pix;
  logic [CW-1:0]         col1;
  logic [NT-1:0]         vmask1, hmask1, hmask4;
  logic                  out_eof, out_err;

  gme_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_valid_i(s_axis_tvalid),
    .pixel_i   (s_axis_tdata[PIXEL_BITS-1:0]),
    .flush_i   (s_axis_tuser),
    .ks_i      (ks_q),
    .erode_i   (erode_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .ctl_o     (ctl1),
    .pix_o     (pix1),
    .col_o     (col1),
    .vmask_o   (vmask1),
    .hmask_o   (hmask1)
  );

  gme_vert #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_vert (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl1),
    .pix_i  (pix1),
    .col_i  (col1),
    .vmask_i(vmask1),
    .hmask_i(hmask1),
    .ctl_o  (ctl4),
    .v_o    (v4),
    .hmask_o(hmask4)
  );

  gme_horz #(
    .MAX_KERNEL(MAX_KERNEL),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_horz (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (ctl4),
    .v_i        (v4),
    .hmask_i    (hmask4),
    .out_valid_o(out_valid),
    .out_pix_o  (out_pix),
    .out_eof_o  (out_eof),
    .out_err_o  (out_err)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDW'(out_pix);
  assign m_axis_tlast  = out_eof;
  assign m_axis_tuser  = out_err;

  // a held result blocks new items
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("item accepted while output stalled");

  // even kernel gives a zero pixel
  a_err_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("config error result carries nonzero pixel");

endmodule
`default_nettype wire
